### rtl/core/rtc_pkg.sv
// shared types, codes and constants for the region table containment block
// no dependencies
`default_nettype none
package rtc_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 64;
    localparam int unsigned FRONT_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_SPAN   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_e_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } status_e_t;

    typedef enum logic [2:0] {
        CL_INSERT,
        CL_REJECT,
        CL_FIND,
        CL_SPAN,
        CL_CLEAR
    } class_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } back_state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] addr;
        logic [31:0] len;
        logic        flag_in;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] region_start;
        logic [31:0] region_len;
        logic        flag_out;
        logic [31:0] span;
    } out_word_t;

    // classified command handed from front to back
    typedef struct packed {
        class_t      cls;
        logic [63:0] addr;
        logic [31:0] len;
        logic        flag;
    } job_t;

    typedef struct packed {
        logic [63:0] start;
        logic [31:0] len;
        logic        flag;
    } entry_t;

endpackage
`default_nettype wire

### rtl/core/rtc_front.sv
// front end: accepts input words, classifies them, holds them in a short queue
// depends on rtc_pkg
`default_nettype none
module rtc_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire rtc_pkg::in_word_t in_word,
    output logic                  job_vld,
    output rtc_pkg::job_t         job,
    input  wire logic             job_take
);
    import rtc_pkg::*;

    localparam int unsigned PW = $clog2(FRONT_DEPTH);

    job_t            q_mem [FRONT_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     cnt_reg, cnt_next;
    logic            do_push, do_pop;
    job_t            new_job;

    // classify the incoming word
    always_comb
    begin
        new_job.addr = in_word.addr;
        new_job.len  = in_word.len;
        new_job.flag = in_word.flag_in;
        case (cmd_e_t'(in_word.cmd))
            CMD_INSERT: new_job.cls = (in_word.len == 32'd0) ? CL_REJECT : CL_INSERT;
            CMD_FIND:   new_job.cls = CL_FIND;
            CMD_SPAN:   new_job.cls = CL_SPAN;
            CMD_CLEAR:  new_job.cls = CL_CLEAR;
            default:    new_job.cls = CL_CLEAR;
        endcase
    end

    assign full    = (cnt_reg == (PW+1)'(FRONT_DEPTH));
    assign job_vld = (cnt_reg != '0);
    assign job     = q_mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = job_take && job_vld;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_ptr_reg] <= new_job;
    end

endmodule
`default_nettype wire

### rtl/core/rtc_back.sv
// back end: walks the region table through its memory read port and builds results
// depends on rtc_pkg
`default_nettype none
module rtc_back #(
    parameter int unsigned TABLE_DEPTH = rtc_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_vld,
    input  wire rtc_pkg::job_t  job,
    output logic                job_take,
    output logic                empty,
    input  wire logic           pop,
    output rtc_pkg::out_word_t  out_word
);
    import rtc_pkg::*;

    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    entry_t              mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] used_reg;

    back_state_t state_reg, state_next;
    logic [IW-1:0] rd_idx_reg;
    logic          ev_vld_reg;
    logic [IW-1:0] ev_idx_reg;
    entry_t        rd_data_reg;

    logic          hit_vld_reg, free_vld_reg, best_vld_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg;
    logic [31:0]   hit_len_reg;
    logic          hit_flag_reg;
    entry_t        best_reg;
    logic [31:0]   span_reg;

    logic          out_vld_reg;
    out_word_t     out_reg;

    // per-entry compare
    logic          ev_used, ge, d_small, find_ok, span_ok, ins_hit;
    logic [63:0]   d;
    logic [32:0]   d_end;
    logic [31:0]   rem;

    // finish-stage signals
    logic          fin_go, we;
    logic [IW-1:0] wr_idx;
    entry_t        wr_ent;
    out_word_t     res;

    always_comb
    begin
        ev_used = used_reg[ev_idx_reg];
        ge      = ev_used && (rd_data_reg.start <= job.addr);
        d       = job.addr - rd_data_reg.start;
        d_small = (d[63:32] == 32'd0);
        d_end   = {1'b0, d[31:0]} + {1'b0, job.len};
        find_ok = ge && d_small && (d_end <= {1'b0, rd_data_reg.len});
        span_ok = ge && d_small && (d[31:0] < rd_data_reg.len);
        rem     = rd_data_reg.len - d[31:0];
        ins_hit = ev_used && (rd_data_reg.start == job.addr);
    end

    // final result and table write
    always_comb
    begin
        we     = 1'b0;
        wr_idx = hit_idx_reg;
        wr_ent.start = job.addr;
        wr_ent.len   = job.len;
        wr_ent.flag  = job.flag;
        res = '0;
        res.status = ST_OK;
        case (job.cls)
            CL_INSERT:
            begin
                if (hit_vld_reg)
                begin
                    we = 1'b1;
                    wr_ent.len  = (hit_len_reg < job.len) ? job.len : hit_len_reg;
                    wr_ent.flag = hit_flag_reg | job.flag;
                end
                else if (free_vld_reg)
                begin
                    we     = 1'b1;
                    wr_idx = free_idx_reg;
                end
                if (we)
                begin
                    res.region_start = wr_ent.start;
                    res.region_len   = wr_ent.len;
                    res.flag_out     = wr_ent.flag;
                end
                else
                    res.status = ST_FULL;
            end
            CL_REJECT: res.status = ST_ZERO;
            CL_FIND:
            begin
                if (best_vld_reg)
                begin
                    res.region_start = best_reg.start;
                    res.region_len   = best_reg.len;
                    res.flag_out     = best_reg.flag;
                end
                else
                    res.status = ST_MISS;
            end
            CL_SPAN:  res.span = span_reg;
            CL_CLEAR: res.status = ST_OK;
            default:  res.status = ST_OK;
        endcase
    end

    assign fin_go   = (state_reg == S_FIN) && (!out_vld_reg || pop);
    assign job_take = fin_go;
    assign empty    = !out_vld_reg;
    assign out_word = out_reg;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (job_vld)
                begin
                    if (job.cls == CL_REJECT || job.cls == CL_CLEAR)
                        state_next = S_FIN;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:  if (rd_idx_reg == LAST_IDX) state_next = S_DRAIN;
            S_DRAIN: state_next = S_FIN;
            S_FIN:   if (fin_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rd_idx_reg  <= '0;
            ev_vld_reg  <= 1'b0;
            used_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ev_vld_reg <= (state_reg == S_SCAN);
            if (state_reg == S_SCAN)
                rd_idx_reg <= IW'(rd_idx_reg + 1'b1);
            else
                rd_idx_reg <= '0;
            if (fin_go && job.cls == CL_CLEAR)
                used_reg <= '0;
            else if (fin_go && we)
                used_reg[wr_idx] <= 1'b1;
            if (fin_go)
                out_vld_reg <= 1'b1;
            else if (pop)
                out_vld_reg <= 1'b0;
        end
    end

    // scan accumulators
    always_ff @(posedge clk)
    begin
        ev_idx_reg <= rd_idx_reg;
        if (state_reg == S_IDLE)
        begin
            hit_vld_reg  <= 1'b0;
            free_vld_reg <= 1'b0;
            best_vld_reg <= 1'b0;
            span_reg     <= '0;
        end
        else if (ev_vld_reg)
        begin
            if (ins_hit && !hit_vld_reg)
            begin
                hit_vld_reg  <= 1'b1;
                hit_idx_reg  <= ev_idx_reg;
                hit_len_reg  <= rd_data_reg.len;
                hit_flag_reg <= rd_data_reg.flag;
            end
            if (!ev_used && !free_vld_reg)
            begin
                free_vld_reg <= 1'b1;
                free_idx_reg <= ev_idx_reg;
            end
            if (find_ok && (!best_vld_reg || rd_data_reg.start < best_reg.start))
            begin
                best_vld_reg <= 1'b1;
                best_reg     <= rd_data_reg;
            end
            if (span_ok && rem > span_reg)
                span_reg <= rem;
        end
        if (fin_go)
            out_reg <= res;
    end

    // table memory, one read and one write port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_idx_reg];
        if (fin_go && we)
            mem[wr_idx] <= wr_ent;
    end

endmodule
`default_nettype wire

### rtl/core/region_table_containment_top.sv
// region table containment: insert, find and span walk the whole table (one
// table entry per cycle through the memory read port, then a drain state for the
// registered read data, then a finish state); clear and rejected inserts go
// straight to the finish state; a new word is not taken until the last one finishes
// reset clears all used marks at once; table contents need no clearing pass
// depends on rtc_pkg, rtc_front, rtc_back
`default_nettype none
module region_table_containment_top #(
    parameter int unsigned TABLE_DEPTH = rtc_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire rtc_pkg::in_word_t in_word,
    output logic                   empty,
    input  wire logic              pop,
    output rtc_pkg::out_word_t     out_word
);
    import rtc_pkg::*;

    logic job_vld, job_take;
    job_t job;

    // front: accept and classify
    rtc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_word  (in_word),
        .job_vld  (job_vld),
        .job      (job),
        .job_take (job_take)
    );

    // back: table walk and result
    rtc_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_vld  (job_vld),
        .job      (job),
        .job_take (job_take),
        .empty    (empty),
        .pop      (pop),
        .out_word (out_word)
    );

endmodule
`default_nettype wire

### verif/tb.sv
// testbench for region_table_containment_top: directed and random insert, find,
// span and clear words checked against an in-bench table predictor
// depends on rtc_pkg and region_table_containment_top
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rtc_pkg::*;

    localparam int DEPTH = 64;
    localparam int STALL_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full;
    logic empty;
    in_word_t in_word = '0;
    out_word_t out_word;

    // predicted table contents
    logic        tbl_used [DEPTH];
    logic [63:0] tbl_start [DEPTH];
    logic [31:0] tbl_len [DEPTH];
    logic        tbl_flag [DEPTH];

    out_word_t expected_words[$];
    int errors = 0;
    int sent = 0;
    int checked = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    int n_insert = 0, n_find = 0, n_span = 0, n_clear = 0;
    logic [63:0] known_starts[$];

    region_table_containment_top #(.TABLE_DEPTH(DEPTH)) u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_word(in_word),
        .empty(empty), .pop(pop), .out_word(out_word)
    );

    always #2 clk = ~clk;

    // compute the expected result word and update the table copy
    function automatic out_word_t predict_region_op(in_word_t w);
        out_word_t r;
        int hit;
        int free_idx;
        logic [64:0] d;
        logic [64:0] top;
        logic [31:0] best_span;
        r = '0;
        hit = -1;
        free_idx = -1;
        best_span = '0;
        case (cmd_e_t'(w.cmd))
            CMD_INSERT:
            begin
                if (w.len == 0)
                begin
                    r.status = ST_ZERO;
                    return r;
                end
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (tbl_used[i])
                    begin
                        if (tbl_start[i] == w.addr && hit < 0) hit = i;
                    end
                    else if (free_idx < 0)
                        free_idx = i;
                end
                if (hit < 0)
                begin
                    if (free_idx < 0)
                    begin
                        r.status = ST_FULL;
                        return r;
                    end
                    hit = free_idx;
                    tbl_used[hit] = 1'b1;
                    tbl_start[hit] = w.addr;
                    tbl_len[hit] = w.len;
                    tbl_flag[hit] = 1'b0;
                end
                if (tbl_len[hit] < w.len) tbl_len[hit] = w.len;
                tbl_flag[hit] = tbl_flag[hit] | w.flag_in;
                r.status = ST_OK;
                r.region_start = tbl_start[hit];
                r.region_len = tbl_len[hit];
                r.flag_out = tbl_flag[hit];
            end
            CMD_FIND:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (!tbl_used[i] || tbl_start[i] > w.addr) continue;
                    d = {1'b0, w.addr} - {1'b0, tbl_start[i]};
                    if (d > {33'd0, tbl_len[i]}) continue;
                    top = d + {33'd0, w.len};
                    if (top > {33'd0, tbl_len[i]}) continue;
                    if (hit < 0 || tbl_start[i] < tbl_start[hit]) hit = i;
                end
                if (hit < 0)
                    r.status = ST_MISS;
                else
                begin
                    r.status = ST_OK;
                    r.region_start = tbl_start[hit];
                    r.region_len = tbl_len[hit];
                    r.flag_out = tbl_flag[hit];
                end
            end
            CMD_SPAN:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (!tbl_used[i] || tbl_start[i] > w.addr) continue;
                    d = {1'b0, w.addr} - {1'b0, tbl_start[i]};
                    if (d < {33'd0, tbl_len[i]})
                        if (tbl_len[i] - d[31:0] > best_span)
                            best_span = tbl_len[i] - d[31:0];
                end
                r.status = ST_OK;
                r.span = best_span;
            end
            default:
            begin
                for (int i = 0; i < DEPTH; i++) tbl_used[i] = 1'b0;
                r.status = ST_OK;
            end
        endcase
        return r;
    endfunction

    // send one word, predicting its result when accepted
    task automatic send_word(in_word_t w);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (full) @(posedge clk);
        expected_words.push_back(predict_region_op(w));
        sent++;
        case (cmd_e_t'(w.cmd))
            CMD_INSERT: n_insert++;
            CMD_FIND:   n_find++;
            CMD_SPAN:   n_span++;
            default:    n_clear++;
        endcase
    endtask

    function automatic in_word_t make_word(cmd_e_t c, logic [63:0] a, logic [31:0] l,
                                           logic f);
        in_word_t w;
        w.cmd = c;
        w.addr = a;
        w.len = l;
        w.flag_in = f;
        return w;
    endfunction

    // receiver side: random pop and result check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                out_word_t e;
                quiet_cycles <= 0;
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    e = expected_words.pop_front();
                    checked++;
                    if (out_word.status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, out_word.status);
                        errors++;
                    end
                    if (out_word.region_start !== e.region_start)
                    begin
                        $error("region_start exp %h got %h", e.region_start,
                               out_word.region_start);
                        errors++;
                    end
                    if (out_word.region_len !== e.region_len)
                    begin
                        $error("region_len exp %h got %h", e.region_len,
                               out_word.region_len);
                        errors++;
                    end
                    if (out_word.flag_out !== e.flag_out)
                    begin
                        $error("flag_out exp %0d got %0d", e.flag_out, out_word.flag_out);
                        errors++;
                    end
                    if (out_word.span !== e.span)
                    begin
                        $error("span exp %h got %h", e.span, out_word.span);
                        errors++;
                    end
                end
            end
            else if (push && !full)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            pop <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any accepted word or popped result
    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (expected_words.size() != 0) @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
    endtask

    // random but realistic address, reusing known starts
    function automatic logic [63:0] pick_addr();
        logic [63:0] a;
        int k;
        k = $urandom_range(9, 0);
        if (known_starts.size() != 0 && k < 6)
        begin
            a = known_starts[$urandom_range(known_starts.size() - 1, 0)];
            if (k >= 3) a = a + $urandom_range(300, 0);
        end
        else if (k == 6)
            a = {$urandom, $urandom};
        else
            a = {{32{k[0]}}, $urandom} & 64'hFFFF_FFFF_FFFF_F000 | $urandom_range(4095, 0);
        return a;
    endfunction

    function automatic logic [31:0] pick_len();
        case ($urandom_range(7, 0))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(512, 1);
        endcase
    endfunction

    // extremes, zero size, growth, sticky mark, wrap-free ends, find/span misses
    task automatic test_directed();
        send_word(make_word(CMD_INSERT, 64'h1000, 32'd0, 1'b1));
        send_word(make_word(CMD_FIND, 64'h1000, 32'd0, 1'b0));
        send_word(make_word(CMD_SPAN, 64'h1000, 32'd0, 1'b0));
        send_word(make_word(CMD_INSERT, 64'h1000, 32'd16, 1'b1));
        send_word(make_word(CMD_INSERT, 64'h1000, 32'd8, 1'b0));
        send_word(make_word(CMD_INSERT, 64'h1000, 32'd64, 1'b0));
        send_word(make_word(CMD_INSERT, 64'h1008, 32'd200, 1'b0));
        send_word(make_word(CMD_FIND, 64'h1010, 32'd8, 1'b0));
        send_word(make_word(CMD_FIND, 64'h1040, 32'd0, 1'b0));
        send_word(make_word(CMD_FIND, 64'h1040, 32'd1, 1'b0));
        send_word(make_word(CMD_SPAN, 64'h1010, 32'd5, 1'b1));
        send_word(make_word(CMD_SPAN, 64'h0fff, 32'd0, 1'b0));
        send_word(make_word(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_word(make_word(CMD_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        send_word(make_word(CMD_SPAN, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0));
        send_word(make_word(CMD_INSERT, 64'h0, 32'hFFFF_FFFF, 1'b0));
        send_word(make_word(CMD_FIND, 64'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        send_word(make_word(CMD_SPAN, 64'h0, 32'hFFFF_FFFF, 1'b0));
        send_word(make_word(CMD_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_word(make_word(CMD_FIND, 64'h1010, 32'd0, 1'b0));
        send_word(make_word(CMD_SPAN, 64'h1010, 32'd0, 1'b0));
    endtask

    // fill past capacity to hit the full table case, then update and clear
    task automatic test_table_full();
        for (int i = 0; i < DEPTH + 2; i++)
            send_word(make_word(CMD_INSERT, 64'h10_0000 + i * 64'h100, 32'h80, i[0]));
        send_word(make_word(CMD_INSERT, 64'h10_0000, 32'h400, 1'b0));
        send_word(make_word(CMD_SPAN, 64'h10_0010, 32'd0, 1'b0));
        send_word(make_word(CMD_CLEAR, 64'h0, 32'd0, 1'b0));
        send_word(make_word(CMD_INSERT, 64'h20_0000, 32'h10, 1'b0));
    endtask

    // random sequences of mostly well-formed commands over reused starts
    task automatic test_random(int count);
        in_word_t w;
        int k;
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(99, 0);
            w.addr = pick_addr();
            w.len = pick_len();
            w.flag_in = 1'($urandom_range(1, 0));
            if (k < 40) w.cmd = CMD_INSERT;
            else if (k < 70) w.cmd = CMD_FIND;
            else if (k < 98) w.cmd = CMD_SPAN;
            else w.cmd = CMD_CLEAR;
            if (w.cmd == CMD_INSERT && w.len != 0)
                known_starts.push_back(w.addr);
            if (w.cmd == CMD_CLEAR) known_starts.delete();
            if (known_starts.size() > 80) void'(known_starts.pop_front());
            send_word(w);
        end
    endtask

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            tbl_used[i] = 1'b0;
            tbl_start[i] = '0;
            tbl_len[i] = '0;
            tbl_flag[i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        // idle phases: none, sender only, receiver only, both
        test_random(220);
        send_idle_pct = 46;
        test_random(220);
        send_idle_pct = 0;
        recv_stall_pct = 46;
        test_random(220);
        send_idle_pct = 23;
        recv_stall_pct = 23;
        test_random(220);
        push <= 1'b0;
        wait_drained();
        $display("covered %0d words: %0d insert, %0d find, %0d span, %0d clear",
                 sent, n_insert, n_find, n_span, n_clear);
        $display("checked %0d results under four idle and stall mixes", checked);
        if (errors == 0 && expected_words.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
rtl/core/rtc_pkg.sv
rtl/core/rtc_front.sv
rtl/core/rtc_back.sv
rtl/core/region_table_containment_top.sv
verif/tb.sv
